// ===== sv/dur_pkg.sv =====
// Shared types, codes and constants for the dual ultrasonic ranger warning block.
// Holds the echo-to-centimetre conversion and the blink period map. No dependencies.
package dur_pkg;

    localparam int unsigned TIME_W  = 16;
    localparam int unsigned DIST_W  = 10;
    localparam int unsigned TICKS_W = 8;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned SENS_W  = 2;
    localparam int unsigned ACT_W   = 2;
    localparam int unsigned CFG_W   = 10;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned IN_USER_W  = 8;
    localparam int unsigned OUT_DATA_W = 32;
    localparam int unsigned OUT_FIELD_W = SENS_W + 2 * DIST_W + 5;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ECHO_A = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ECHO_B = 2'd2;

    // sensor codes
    localparam logic [SENS_W-1:0] SENSOR_NONE = 2'd0;
    localparam logic [SENS_W-1:0] SENSOR_A    = 2'd1;
    localparam logic [SENS_W-1:0] SENSOR_B    = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_WARN_DIST = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_DIST  = 2'd1;
    localparam logic [IDX_W-1:0] REG_SCAN_TICKS = 2'd2;

    localparam logic [DIST_W-1:0]  WARN_DIST_RST  = 10'd40;
    localparam logic [DIST_W-1:0]  MAX_DIST_RST   = 10'd380;
    localparam logic [TICKS_W-1:0] SCAN_TICKS_RST = 8'd5;

    // x/116 = (x>>2)/29; (x>>2)/29 = (q * ceil(2^24/29)) >> 24 for q < 2^14
    localparam int unsigned RECIP_SHIFT = 24;
    localparam int unsigned RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP_29 = 20'd578525;
    localparam int unsigned PROD_W = (TIME_W - 2) + RECIP_W;

    localparam logic [CNT_W-1:0] PERIOD_MAX = 3'd4;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             level;
    } t_blink;

    function automatic logic [DIST_W-1:0] echo_cm(input logic [TIME_W-1:0] span);
        logic [TIME_W-3:0] q;
        logic [PROD_W-1:0] p;
        q = span[TIME_W-1:2];
        p = PROD_W'(q) * PROD_W'(RECIP_29);
        return p[RECIP_SHIFT +: DIST_W];
    endfunction

    // range/10 + 1 clamped to 1..4
    function automatic logic [CNT_W-1:0] period_of(input logic [DIST_W-1:0] d);
        logic [CNT_W-1:0] p;
        if (d < 10'd10)      p = 3'd1;
        else if (d < 10'd20) p = 3'd2;
        else if (d < 10'd30) p = 3'd3;
        else                 p = PERIOD_MAX;
        return p;
    endfunction

    function automatic t_blink blink_step(input logic         active,
                                          input t_blink       cur,
                                          input logic [CNT_W-1:0] period);
        t_blink           nxt;
        logic [CNT_W-1:0] inc;
        nxt = cur;
        inc = cur.count + 3'd1;
        if (active) begin
            if (inc >= period) begin
                nxt.count = '0;
                nxt.level = ~cur.level;
            end else begin
                nxt.count = inc;
            end
        end else begin
            nxt.level = 1'b0;
        end
        return nxt;
    endfunction

endpackage

// ===== sv/dual_ultrasonic_ranger_warning.sv =====
// Top level of the dual ultrasonic ranger with proximity warning.
// Depends on dur_pkg for codes, constants and the echo conversion.
//
// Usage:
//   Input stream: s_axis_tdata carries the capture time of an echo edge,
//   s_axis_tuser the action (tick, echo edge of A, echo edge of B).
//   Output stream: one transfer for every input transfer, carrying the sensor
//   to fire now, both distances, both warning flags, buzzer and lamp levels.
//   Config: a write on i_cfg_we stores i_cfg_data into register i_cfg_index
//   (0 warn distance, 1 max distance, 2 scan ticks); other indexes are dropped.
//   Write only while no item is in flight.
// Timing:
//   An accepted item is held in the input register, where the state
//   update is done; its result then goes to the result register, which
//   drives m_axis_tvalid. One item per cycle is taken while the output
//   is not stalled; the echo subtract and reciprocal multiply set the clock.
// Reset empties both pipeline registers and restores all state and registers
// to their defaults. When m_axis_tready is low the result is held and the
// input register still accepts one more item before s_axis_tready drops.
module dual_ultrasonic_ranger_warning (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [15:0] capture_time
    input  logic [dur_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] action, rest zero
    input  logic [dur_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] trigger_sensor, [11:2] distance_a, [21:12] distance_b, [22] warn_a,
    // [23] warn_b, [24] buzzer_on, [25] led_a_lit, [26] led_b_lit, rest zero
    output logic [dur_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [dur_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [dur_pkg::CFG_W-1:0]      i_cfg_data
);
    import dur_pkg::*;

    // config registers
    logic [DIST_W-1:0]  r_warn_dist;
    logic [DIST_W-1:0]  r_max_dist;
    logic [TICKS_W-1:0] r_scan_ticks;

    // input and result registers
    logic               r_in_valid;
    logic [ACT_W-1:0]   r_action;
    logic [TIME_W-1:0]  r_time;
    logic               r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // block state
    logic [TICKS_W-1:0] r_tick_div,  n_tick_div;
    logic [SENS_W-1:0]  r_scan_sens, n_scan_sens;
    logic [SENS_W-1:0]  r_listen,    n_listen;
    logic [1:0]         r_edge_seen, n_edge_seen;
    logic [TIME_W-1:0]  r_start [2];
    logic [TIME_W-1:0]  n_start [2];
    logic [DIST_W-1:0]  r_range [2];
    logic [DIST_W-1:0]  n_range [2];
    logic [1:0]         r_warn,      n_warn;
    t_blink             r_buzz,      n_buzz;
    t_blink             r_lamp [2];
    t_blink             n_lamp [2];
    logic [SENS_W-1:0]  n_trig;
    logic [OUT_DATA_W-1:0] n_out_data;

    logic               advance;
    logic               s_idx;
    logic [TIME_W-1:0]  span;
    logic [DIST_W-1:0]  meas;
    logic [TICKS_W-1:0] tick_inc;
    logic [1:0]         warn_new;
    logic [CNT_W-1:0]   per_a, per_b, per_z;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // echo path: sensor B is slot 1
    assign s_idx = (r_action == ACT_ECHO_B);
    assign span  = r_time - r_start[s_idx];
    assign meas  = echo_cm(span);

    // scan path works on the stored ranges
    assign tick_inc = r_tick_div + 8'd1;
    assign warn_new = {(r_range[1] <= r_warn_dist), (r_range[0] <= r_warn_dist)};
    assign per_a    = period_of(r_range[0]);
    assign per_b    = period_of(r_range[1]);
    assign per_z    = (per_a < per_b) ? per_a : per_b;

    always_comb begin
        n_tick_div  = r_tick_div;
        n_scan_sens = r_scan_sens;
        n_listen    = r_listen;
        n_edge_seen = r_edge_seen;
        n_start     = r_start;
        n_range     = r_range;
        n_warn      = r_warn;
        n_buzz      = r_buzz;
        n_lamp      = r_lamp;
        n_trig      = SENSOR_NONE;
        case (r_action)
            ACT_TICK: begin
                n_tick_div = tick_inc;
                if (tick_inc >= r_scan_ticks) begin
                    n_tick_div  = '0;
                    n_scan_sens = (r_scan_sens == SENSOR_A) ? SENSOR_B : SENSOR_A;
                    n_listen    = n_scan_sens;
                    n_trig      = n_scan_sens;
                    n_warn      = warn_new;
                    n_buzz      = blink_step(|warn_new, r_buzz, per_z);
                    n_lamp[0]   = blink_step(warn_new[0], r_lamp[0], per_a);
                    n_lamp[1]   = blink_step(warn_new[1], r_lamp[1], per_b);
                end
            end
            ACT_ECHO_A, ACT_ECHO_B: begin
                if (r_listen == r_action) begin
                    if (!r_edge_seen[s_idx]) begin
                        n_start[s_idx]     = r_time;
                        n_edge_seen[s_idx] = 1'b1;
                    end else begin
                        if (meas <= r_max_dist) n_range[s_idx] = meas;
                        n_edge_seen[s_idx] = 1'b0;
                        n_listen           = SENSOR_NONE;
                    end
                end
            end
            default: ;  // undefined action: report state only
        endcase
        n_out_data = OUT_DATA_W'({n_lamp[1].level, n_lamp[0].level, n_buzz.level,
                                  n_warn[1], n_warn[0], n_range[1], n_range[0], n_trig});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn_dist  <= WARN_DIST_RST;
            r_max_dist   <= MAX_DIST_RST;
            r_scan_ticks <= SCAN_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WARN_DIST:  r_warn_dist  <= i_cfg_data;
                REG_MAX_DIST:   r_max_dist   <= i_cfg_data;
                REG_SCAN_TICKS: r_scan_ticks <= i_cfg_data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (advance)            r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_action <= s_axis_tuser[ACT_W-1:0];
            r_time   <= s_axis_tdata[TIME_W-1:0];
        end
        if (advance) r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_div  <= '0;
            r_scan_sens <= SENSOR_A;
            r_listen    <= SENSOR_A;
            r_edge_seen <= '0;
            r_start[0]  <= '0;
            r_start[1]  <= '0;
            r_range[0]  <= '0;
            r_range[1]  <= '0;
            r_warn      <= '0;
            r_buzz      <= '0;
            r_lamp[0]   <= '0;
            r_lamp[1]   <= '0;
        end else if (advance) begin
            r_tick_div  <= n_tick_div;
            r_scan_sens <= n_scan_sens;
            r_listen    <= n_listen;
            r_edge_seen <= n_edge_seen;
            r_start     <= n_start;
            r_range     <= n_range;
            r_warn      <= n_warn;
            r_buzz      <= n_buzz;
            r_lamp      <= n_lamp;
        end
    end

endmodule
